[rtl/rrht_pkg.sv]
package rrht_pkg;

	localparam int NUM_EDGES = 4;

	typedef logic signed [1:0] norm_t;
	typedef logic [1:0] edge_idx_t;

	// Edge order: left, max-y, right, min-y.
	localparam edge_idx_t EDGE_LEFT  = 2'd0;
	localparam edge_idx_t EDGE_TOP   = 2'd1;
	localparam edge_idx_t EDGE_RIGHT = 2'd2;
	localparam edge_idx_t EDGE_BOT   = 2'd3;

	localparam norm_t NORM_X [NUM_EDGES] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
	localparam norm_t NORM_Y [NUM_EDGES] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};

endpackage

[rtl/ray_rectangle_hit_time_core.sv]
// Ray segment against axis-aligned rectangle: each item carries a segment
// (start, direction) and a rectangle (min corner, size); the block tests the
// edges left, max-y, right, min-y in parallel, in that priority order, and returns the earliest
// segment parameter t in [0,1] (unsigned Q1.TIME_FRAC_BITS, truncated) whose
// edge parameter also lies in [0,1], with that edge's outward normal. Ties
// keep the earlier edge; parallel edges and empty sides never hit; with no
// hit the result is hit=0, time 0, normal (-1,0). The pipeline takes one
// item per cycle while out_stall is low; each item passes through three front
// stages (edge offsets, six products, bound checks), one stage per quotient bit
// of the four parallel restoring dividers, and the output register that picks
// the earliest edge. Stall backs up only through occupied stages, so bubbles
// are squeezed out.
module ray_rectangle_hit_time_core #(
	parameter int COORD_BITS = 24,
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_BITS-1:0] ray_start_x,
	input  logic signed [COORD_BITS-1:0] ray_start_y,
	input  logic signed [COORD_BITS-1:0] ray_dir_x,
	input  logic signed [COORD_BITS-1:0] ray_dir_y,
	input  logic signed [COORD_BITS-1:0] rect_x,
	input  logic signed [COORD_BITS-1:0] rect_y,
	input  logic [COORD_BITS-2:0] rect_width,
	input  logic [COORD_BITS-2:0] rect_height,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output logic [TIME_FRAC_BITS:0] hit_time,
	output logic signed [1:0] normal_x,
	output logic signed [1:0] normal_y
);
	import rrht_pkg::*;

	localparam int C = COORD_BITS;
	localparam int F = TIME_FRAC_BITS;
	localparam int QW = C + 2;       // edge start minus ray start
	localparam int PW = 2 * C + 2;   // offset times direction
	localparam int NW = PW + 1;      // cross product difference
	localparam int LW = 2 * C - 1;   // |dir| times side length
	localparam int TW = F + 1;

	// ---------------- stage 1: offsets from the ray start ----------------
	logic v1_s1;
	logic en1, en2, en3, en_out;
	logic signed [QW-1:0] qx0_s1, qx1_s1, qy0_s1, qy1_s1;
	logic signed [C-1:0] rx_s1, ry_s1;
	logic [C-2:0] w_s1, h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1 <= in_valid;
		end
	end

	// qx0/qy0 come from the min corner, qx1/qy1 from the far corner.
	always_ff @(posedge clk) begin
		if (en1) begin
			qx0_s1 <= QW'(rect_x) - QW'(ray_start_x);
			qy0_s1 <= QW'(rect_y) - QW'(ray_start_y);
			qx1_s1 <= QW'(rect_x) + QW'(rect_width) - QW'(ray_start_x);
			qy1_s1 <= QW'(rect_y) + QW'(rect_height) - QW'(ray_start_y);
			rx_s1 <= ray_dir_x;
			ry_s1 <= ray_dir_y;
			w_s1 <= rect_width;
			h_s1 <= rect_height;
		end
	end

	// ---------------- stage 2: products ----------------
	logic v2_s2;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic [LW-1:0] limv_s2, limh_s2;
	logic signed [QW-1:0] qx0_s2, qx1_s2, qy0_s2, qy1_s2;
	logic [C-1:0] arx_s2, ary_s2;
	logic rxn_s2, ryn_s2, vok_s2, hok_s2;
	logic [C-1:0] arx_c, ary_c;

	assign arx_c = rx_s1[C-1] ? C'(~rx_s1 + 1'b1) : C'(rx_s1);
	assign ary_c = ry_s1[C-1] ? C'(~ry_s1 + 1'b1) : C'(ry_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (en2) begin
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			pa_s2 <= PW'(qx0_s1) * PW'(ry_s1);
			pb_s2 <= PW'(qx1_s1) * PW'(ry_s1);
			pc_s2 <= PW'(qy0_s1) * PW'(rx_s1);
			pd_s2 <= PW'(qy1_s1) * PW'(rx_s1);
			limv_s2 <= LW'(arx_c) * LW'(h_s1);
			limh_s2 <= LW'(ary_c) * LW'(w_s1);
			qx0_s2 <= qx0_s1;
			qx1_s2 <= qx1_s1;
			qy0_s2 <= qy0_s1;
			qy1_s2 <= qy1_s1;
			arx_s2 <= arx_c;
			ary_s2 <= ary_c;
			rxn_s2 <= rx_s1[C-1];
			ryn_s2 <= ry_s1[C-1];
			// zero direction component or empty side: denominator is zero
			vok_s2 <= (rx_s1 != '0) && (h_s1 != '0);
			hok_s2 <= (ry_s1 != '0) && (w_s1 != '0);
		end
	end

	// ---------------- stage 3: range checks per edge ----------------
	logic v3_s3;
	logic [NUM_EDGES-1:0] hit_s3, eq_s3;
	logic [NUM_EDGES-1:0][C-1:0] rem_s3, div_s3;

	logic signed [NW-1:0] nraw [NUM_EDGES];
	logic signed [QW-1:0] traw [NUM_EDGES];
	logic [NUM_EDGES-1:0] nneg, tneg, dok;
	logic [LW-1:0] lim [NUM_EDGES];
	logic [C-1:0] dv [NUM_EDGES];
	logic [NUM_EDGES-1:0] hit_c, eq_c;
	logic [NUM_EDGES-1:0][C-1:0] rem_c, div_c;

	// Edge-specific operands; sign flips normalize the denominator positive.
	always_comb begin
		nraw[EDGE_LEFT]  = NW'(pa_s2) - NW'(pc_s2);
		nraw[EDGE_TOP]   = NW'(pa_s2) - NW'(pd_s2);
		nraw[EDGE_RIGHT] = NW'(pb_s2) - NW'(pd_s2);
		nraw[EDGE_BOT]   = NW'(pb_s2) - NW'(pc_s2);
		traw[EDGE_LEFT]  = qx0_s2;
		traw[EDGE_TOP]   = qy1_s2;
		traw[EDGE_RIGHT] = qx1_s2;
		traw[EDGE_BOT]   = qy0_s2;
		nneg[EDGE_LEFT]  = rxn_s2;
		nneg[EDGE_TOP]   = !ryn_s2;
		nneg[EDGE_RIGHT] = !rxn_s2;
		nneg[EDGE_BOT]   = ryn_s2;
		tneg[EDGE_LEFT]  = rxn_s2;
		tneg[EDGE_TOP]   = ryn_s2;
		tneg[EDGE_RIGHT] = rxn_s2;
		tneg[EDGE_BOT]   = ryn_s2;
		lim[EDGE_LEFT]   = limv_s2;
		lim[EDGE_TOP]    = limh_s2;
		lim[EDGE_RIGHT]  = limv_s2;
		lim[EDGE_BOT]    = limh_s2;
		dv[EDGE_LEFT]    = arx_s2;
		dv[EDGE_TOP]     = ary_s2;
		dv[EDGE_RIGHT]   = arx_s2;
		dv[EDGE_BOT]     = ary_s2;
		dok[EDGE_LEFT]   = vok_s2;
		dok[EDGE_TOP]    = hok_s2;
		dok[EDGE_RIGHT]  = vok_s2;
		dok[EDGE_BOT]    = hok_s2;
	end

	always_comb begin
		logic signed [NW-1:0] nn;
		logic signed [QW-1:0] tt;
		logic uok, tok;
		for (int i = 0; i < NUM_EDGES; i++) begin
			nn = nneg[i] ? -nraw[i] : nraw[i];
			tt = tneg[i] ? -traw[i] : traw[i];
			uok = !nn[NW-1] && (nn[NW-2:0] <= (NW-1)'(lim[i]));
			tok = !tt[QW-1] && (tt[QW-2:0] <= (QW-1)'(dv[i]));
			hit_c[i] = dok[i] && uok && tok;
			eq_c[i] = (tt[QW-2:0] == (QW-1)'(dv[i]));
			rem_c[i] = tt[C-1:0];
			div_c[i] = dv[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3 <= 1'b0;
		end else if (en3) begin
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			hit_s3 <= hit_c;
			eq_s3 <= eq_c;
			rem_s3 <= rem_c;
			div_s3 <= div_c;
		end
	end

	// ---------------- quotient pipeline ----------------
	logic div_stall, dv_valid;
	logic [NUM_EDGES-1:0] dv_hit, dv_eq;
	logic [NUM_EDGES-1:0][F-1:0] dv_quo;

	rrht_div_pipe #(
		.COORD_BITS(C),
		.TIME_FRAC_BITS(F)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v3_s3),
		.in_stall(div_stall),
		.in_hit(hit_s3),
		.in_eq(eq_s3),
		.in_rem(rem_s3),
		.in_div(div_s3),
		.out_valid(dv_valid),
		.out_stall(!en_out),
		.out_hit(dv_hit),
		.out_eq(dv_eq),
		.out_quo(dv_quo)
	);

	// Advance each stage when empty or when the next one moves.
	assign en3 = !v3_s3 || !div_stall;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign in_stall = !en1;

	// ---------------- earliest edge and output register ----------------
	logic out_valid_q, hit_q;
	logic [TW-1:0] time_q;
	norm_t nx_q, ny_q;
	logic have_c;
	logic [TW-1:0] best_c;
	edge_idx_t sel_c;

	assign en_out = !out_valid_q || !out_stall;

	// Strict less-than keeps the earlier edge on a tie.
	always_comb begin
		logic [TW-1:0] t;
		have_c = 1'b0;
		best_c = '0;
		sel_c = EDGE_LEFT;
		for (int i = 0; i < NUM_EDGES; i++) begin
			t = dv_eq[i] ? TW'(1) << F : {1'b0, dv_quo[i]};
			if (dv_hit[i] && (!have_c || t < best_c)) begin
				have_c = 1'b1;
				best_c = t;
				sel_c = edge_idx_t'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			hit_q <= have_c;
			time_q <= best_c;
			nx_q <= NORM_X[sel_c];
			ny_q <= NORM_Y[sel_c];
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign hit_time = time_q;
	assign normal_x = nx_q;
	assign normal_y = ny_q;

	// A miss must report the default left normal and zero time.
	a_miss_default: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_time == '0 && normal_x == -2'sd1 && normal_y == 2'sd0)
		else $error("miss result not in default form");

	// Time never exceeds one.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit_time <= (TW'(1) << F))
		else $error("hit time above one");

	// Input stall only when the first stage is holding an item.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v1_s1)
		else $error("input stalled with empty first stage");

	// A hit always carries exactly one nonzero normal component.
	a_hit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (normal_x == 2'sd0) != (normal_y == 2'sd0))
		else $error("hit normal malformed");

endmodule

[rtl/rrht_div_pipe.sv]
module rrht_div_pipe #(
	parameter int COORD_BITS = 24,
	parameter int TIME_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [rrht_pkg::NUM_EDGES-1:0] in_hit,
	input  logic [rrht_pkg::NUM_EDGES-1:0] in_eq,
	input  logic [rrht_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] in_rem,
	input  logic [rrht_pkg::NUM_EDGES-1:0][COORD_BITS-1:0] in_div,
	output logic out_valid,
	input  logic out_stall,
	output logic [rrht_pkg::NUM_EDGES-1:0] out_hit,
	output logic [rrht_pkg::NUM_EDGES-1:0] out_eq,
	output logic [rrht_pkg::NUM_EDGES-1:0][TIME_FRAC_BITS-1:0] out_quo
);
	import rrht_pkg::*;

	localparam int C = COORD_BITS;
	localparam int F = TIME_FRAC_BITS;

	// One restoring quotient bit per stage, four lanes side by side.
	logic v_s [F];
	logic en [F];
	logic [NUM_EDGES-1:0] hit_s [F];
	logic [NUM_EDGES-1:0] eq_s [F];
	logic [NUM_EDGES-1:0][C-1:0] rem_s [F];
	logic [NUM_EDGES-1:0][C-1:0] div_s [F];
	logic [NUM_EDGES-1:0][F-1:0] quo_s [F];

	genvar k;
	generate
		for (k = 0; k < F; k++) begin : g_stage
			logic src_v;
			logic [NUM_EDGES-1:0] src_hit;
			logic [NUM_EDGES-1:0] src_eq;
			logic [NUM_EDGES-1:0][C-1:0] src_rem;
			logic [NUM_EDGES-1:0][C-1:0] src_div;
			logic [NUM_EDGES-1:0][F-1:0] src_quo;
			logic [NUM_EDGES-1:0][C-1:0] nxt_rem;
			logic [NUM_EDGES-1:0][F-1:0] nxt_quo;

			if (k == 0) begin : g_first
				assign src_v = in_valid;
				assign src_hit = in_hit;
				assign src_eq = in_eq;
				assign src_rem = in_rem;
				assign src_div = in_div;
				assign src_quo = '0;
			end else begin : g_next
				assign src_v = v_s[k-1];
				assign src_hit = hit_s[k-1];
				assign src_eq = eq_s[k-1];
				assign src_rem = rem_s[k-1];
				assign src_div = div_s[k-1];
				assign src_quo = quo_s[k-1];
			end

			if (k == F - 1) begin : g_last
				assign en[k] = !v_s[k] || !out_stall;
			end else begin : g_mid
				assign en[k] = !v_s[k] || en[k+1];
			end

			always_comb begin
				logic [C:0] r2;
				logic [C:0] dd;
				logic ge;
				for (int i = 0; i < NUM_EDGES; i++) begin
					r2 = {src_rem[i], 1'b0};
					dd = {1'b0, src_div[i]};
					ge = (r2 >= dd);
					nxt_rem[i] = ge ? C'(r2 - dd) : C'(r2);
					nxt_quo[i] = {src_quo[i][F-2:0], ge};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= src_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					hit_s[k] <= src_hit;
					eq_s[k] <= src_eq;
					rem_s[k] <= nxt_rem;
					div_s[k] <= src_div;
					quo_s[k] <= nxt_quo;
				end
			end
		end
	endgenerate

	assign in_stall = !en[0];
	assign out_valid = v_s[F-1];
	assign out_hit = hit_s[F-1];
	assign out_eq = eq_s[F-1];
	assign out_quo = quo_s[F-1];

endmodule
